/* rtl/usbcin_pkg.sv */
// shared types and constants of the usb control in data stage sequencer
package usbcin_pkg;

	// maximum packet size of the control endpoint
	localparam int unsigned PKT_BYTES = 8;
	// width that holds 0 .. PKT_BYTES
	localparam int unsigned ROOM_W = $clog2(PKT_BYTES + 1);

	localparam int unsigned MODE_W = 3;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned FILL_W = 4;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned NBYTES_W = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_START    = 3'd0,
		MODE_IN_READY = 3'd1,
		MODE_OUT      = 3'd2,
		MODE_SETUP    = 3'd3,
		MODE_DISC     = 3'd4,
		MODE_SUSP     = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY     = 3'd0,
		ST_DONE     = 3'd1,
		ST_DISC     = 3'd2,
		ST_SUSP     = 3'd3,
		ST_ABORTED  = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DATA = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  request_length;
		logic [FILL_W-1:0] fifo_fill;
	} evt_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                send_packet;
		logic [NBYTES_W-1:0] packet_bytes;
		logic [LEN_W-1:0]    packet_offset;
	} res_t;

endpackage

/* rtl/usbcin_evt_if.sv */
// bus event channel
interface usbcin_evt_if;
	logic                              valid;
	logic                              ready;
	logic [usbcin_pkg::MODE_W-1:0]     mode;
	logic [usbcin_pkg::LEN_W-1:0]      length;
	logic [usbcin_pkg::LEN_W-1:0]      request_length;
	logic [usbcin_pkg::FILL_W-1:0]     fifo_fill;

	modport source (output valid, mode, length, request_length, fifo_fill, input ready);
	modport sink (input valid, mode, length, request_length, fifo_fill, output ready);
endinterface

/* rtl/usbcin_res_if.sv */
// packet result channel
interface usbcin_res_if;
	logic                              valid;
	logic                              ready;
	logic [usbcin_pkg::STATUS_W-1:0]   status;
	logic                              send_packet;
	logic [usbcin_pkg::NBYTES_W-1:0]   packet_bytes;
	logic [usbcin_pkg::LEN_W-1:0]      packet_offset;

	modport source (output valid, status, send_packet, packet_bytes, packet_offset, input ready);
	modport sink (input valid, status, send_packet, packet_bytes, packet_offset, output ready);
endinterface

/* rtl/usbcin_seq.sv */
// transfer state registers with next-state and result logic
module usbcin_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  usbcin_pkg::evt_t   item,
	output usbcin_pkg::res_t   result
);

	usbcin_pkg::phase_t                  phase_q, phase_d;
	logic [usbcin_pkg::LEN_W-1:0]        remaining_q, remaining_d;
	logic [usbcin_pkg::LEN_W-1:0]        offset_q, offset_d;
	logic                                full_q, full_d;

	logic [usbcin_pkg::LEN_W-1:0]        clamped;
	logic [usbcin_pkg::ROOM_W-1:0]       fill_x;
	logic [usbcin_pkg::ROOM_W-1:0]       room;
	logic [usbcin_pkg::ROOM_W-1:0]       nbytes;
	logic [usbcin_pkg::ROOM_W:0]         fill_sum;
	logic                                pkt_full;
	logic [usbcin_pkg::LEN_W-1:0]        rem_after;
	logic                                active;

	localparam logic [usbcin_pkg::ROOM_W-1:0] PKT_W = usbcin_pkg::ROOM_W'(usbcin_pkg::PKT_BYTES);

	// packet sizing
	assign clamped = (item.length > item.request_length) ? item.request_length : item.length;
	assign fill_x = usbcin_pkg::ROOM_W'(item.fifo_fill);
	assign room = (fill_x < PKT_W) ? PKT_W - fill_x : '0;
	assign nbytes = (remaining_q < usbcin_pkg::LEN_W'(room))
		? remaining_q[usbcin_pkg::ROOM_W-1:0] : room;
	assign fill_sum = {1'b0, fill_x} + {1'b0, nbytes};
	assign pkt_full = (fill_sum == {1'b0, PKT_W});
	assign rem_after = remaining_q - usbcin_pkg::LEN_W'(nbytes);
	assign active = (phase_q == usbcin_pkg::PH_DATA) || (phase_q == usbcin_pkg::PH_WAIT);

	// next state
	always_comb begin
		phase_d = phase_q;
		remaining_d = remaining_q;
		offset_d = offset_q;
		full_d = full_q;
		if (item.mode == usbcin_pkg::MODE_START) begin
			remaining_d = clamped;
			offset_d = '0;
			full_d = 1'b0;
			phase_d = (clamped != '0) ? usbcin_pkg::PH_DATA : usbcin_pkg::PH_WAIT;
		end else if (active) begin
			case (item.mode)
				usbcin_pkg::MODE_IN_READY: begin
					if (phase_q == usbcin_pkg::PH_DATA) begin
						full_d = pkt_full;
						remaining_d = rem_after;
						offset_d = offset_q + usbcin_pkg::LEN_W'(nbytes);
						if (rem_after == '0 && !pkt_full) begin
							phase_d = usbcin_pkg::PH_WAIT;
						end
					end
				end
				usbcin_pkg::MODE_OUT, usbcin_pkg::MODE_SETUP,
				usbcin_pkg::MODE_DISC, usbcin_pkg::MODE_SUSP: begin
					phase_d = usbcin_pkg::PH_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	// result of this beat
	always_comb begin
		result = '0;
		result.status = usbcin_pkg::ST_BUSY;
		if (item.mode == usbcin_pkg::MODE_START) begin
			result.send_packet = (clamped == '0) && (item.length == '0);
		end else if (!active) begin
			result.status = usbcin_pkg::ST_IGNORED;
		end else begin
			case (item.mode)
				usbcin_pkg::MODE_IN_READY: begin
					if (phase_q == usbcin_pkg::PH_DATA) begin
						result.send_packet = 1'b1;
						result.packet_bytes = usbcin_pkg::NBYTES_W'(nbytes);
						result.packet_offset = offset_q;
					end
				end
				usbcin_pkg::MODE_OUT:   result.status = usbcin_pkg::ST_DONE;
				usbcin_pkg::MODE_SETUP: result.status = usbcin_pkg::ST_ABORTED;
				usbcin_pkg::MODE_DISC:  result.status = usbcin_pkg::ST_DISC;
				usbcin_pkg::MODE_SUSP:  result.status = usbcin_pkg::ST_SUSP;
				default:                result.status = usbcin_pkg::ST_BUSY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= usbcin_pkg::PH_IDLE;
			remaining_q <= '0;
			offset_q <= '0;
			full_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			remaining_q <= remaining_d;
			offset_q <= offset_d;
			full_q <= full_d;
		end
	end

endmodule

/* rtl/usb_control_in_data_stage_top.sv */
// top level of the usb control transfer in data stage packet sequencer
// path: a beat is held in the input register, then in the result register that drives res
// throughput: one event per cycle, sustained while the result side takes beats
// the input register stalls only while the result register holds a beat and res.ready is low
// reset: arst_n clears both stage valids and puts the transfer state to idle
// with nothing left to send and offset zero
module usb_control_in_data_stage_top (
	input  logic                clk,
	input  logic                arst_n,
	usbcin_evt_if.sink          evt,
	usbcin_res_if.source        res
);

	// stage 1: registered event beat
	logic                       vld_s1;
	usbcin_pkg::evt_t           evt_s1;
	// stage 2: registered result beat
	logic                       vld_s2;
	usbcin_pkg::res_t           res_s2;

	usbcin_pkg::res_t           step_res;
	logic                       adv_s2;
	logic                       commit;

	// result register can load when empty or being drained
	assign adv_s2 = !vld_s2 || res.ready;
	// an event updates the transfer state exactly when it moves into the result register
	assign commit = vld_s1 && adv_s2;
	assign evt.ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			vld_s1 <= evt.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1.mode <= evt.mode;
			evt_s1.length <= evt.length;
			evt_s1.request_length <= evt.request_length;
			evt_s1.fifo_fill <= evt.fifo_fill;
		end
	end

	// sequencer: state plus single pass packet sizing
	usbcin_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (commit),
		.item    (evt_s1),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_s2 <= step_res;
		end
	end

	// result beat out
	assign res.valid = vld_s2;
	assign res.status = res_s2.status;
	assign res.send_packet = res_s2.send_packet;
	assign res.packet_bytes = res_s2.packet_bytes;
	assign res.packet_offset = res_s2.packet_offset;

endmodule

/* verif/tb_usb_control_in_data_stage_top.sv */
// self-checking testbench of the usb control in data stage packet sequencer
`timescale 1ns / 1ps

module tb_usb_control_in_data_stage_top;

	// mode codes outside the defined events, the block treats them as no event
	localparam logic [usbcin_pkg::MODE_W-1:0] MODE_RSVD_6 = 3'd6;
	localparam logic [usbcin_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

	// stop offering random transfers once this many transfer beats have gone in; loose events do not count
	localparam int unsigned RANDOM_ITEMS = 1750;
	// watchdog limit, set with ample headroom over the slowest correct run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// drain time after the last expected result, so a stray result can still show up
	localparam int unsigned DRAIN_CYCLES = 16;
	// accepted beats before the receiver's long hold-off kicks in
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned HOLD_CYCLES = 400;

	// tracks the transfer state and the packets the block owes the host
	class packet_tracker;
		usbcin_pkg::phase_t                phase;
		logic [usbcin_pkg::LEN_W-1:0]      remaining;
		logic [usbcin_pkg::LEN_W-1:0]      next_offset;
		bit                                last_full;
		usbcin_pkg::res_t                  pending_packets[$];
		int unsigned                       errors;
		int unsigned                       accepted;

		function new();
			phase = usbcin_pkg::PH_IDLE;
			remaining = '0;
			next_offset = '0;
			last_full = 1'b0;
			errors = 0;
			accepted = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 200)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		// works out the one result that an accepted event causes
		task predict_packet(input usbcin_pkg::evt_t e);
			usbcin_pkg::res_t r;
			int unsigned      clamped;
			int unsigned      room;
			int unsigned      n;
			r = '0;
			accepted++;
			if (e.mode == usbcin_pkg::MODE_START) begin
				clamped = (e.length > e.request_length) ? e.request_length : e.length;
				remaining = usbcin_pkg::LEN_W'(clamped);
				next_offset = '0;
				last_full = 1'b0;
				if (clamped != 0) begin
					phase = usbcin_pkg::PH_DATA;
				end else begin
					phase = usbcin_pkg::PH_WAIT;
					// zero-length packet only when the device itself offers nothing
					r.send_packet = (e.length == 0);
				end
			end else if (phase == usbcin_pkg::PH_IDLE || e.mode > usbcin_pkg::MODE_SUSP) begin
				r.status = (phase == usbcin_pkg::PH_IDLE) ? usbcin_pkg::ST_IGNORED
					: usbcin_pkg::ST_BUSY;
			end else begin
				case (e.mode)
					usbcin_pkg::MODE_IN_READY: begin
						if (phase == usbcin_pkg::PH_DATA) begin
							room = (e.fifo_fill < usbcin_pkg::PKT_BYTES)
								? usbcin_pkg::PKT_BYTES - e.fifo_fill : 0;
							n = (remaining < room) ? remaining : room;
							r.send_packet = 1'b1;
							r.packet_bytes = n[usbcin_pkg::NBYTES_W-1:0];
							r.packet_offset = next_offset;
							last_full = (e.fifo_fill + n) == usbcin_pkg::PKT_BYTES;
							remaining = remaining - n[usbcin_pkg::LEN_W-1:0];
							next_offset = next_offset + n[usbcin_pkg::LEN_W-1:0];
							if (remaining == 0 && !last_full)
								phase = usbcin_pkg::PH_WAIT;
						end
					end
					usbcin_pkg::MODE_OUT: begin
						phase = usbcin_pkg::PH_IDLE;
						r.status = usbcin_pkg::ST_DONE;
					end
					usbcin_pkg::MODE_SETUP: begin
						phase = usbcin_pkg::PH_IDLE;
						r.status = usbcin_pkg::ST_ABORTED;
					end
					usbcin_pkg::MODE_DISC: begin
						phase = usbcin_pkg::PH_IDLE;
						r.status = usbcin_pkg::ST_DISC;
					end
					default: begin
						phase = usbcin_pkg::PH_IDLE;
						r.status = usbcin_pkg::ST_SUSP;
					end
				endcase
			end
			pending_packets.push_back(r);
		endtask

		task check_packet(input usbcin_pkg::res_t got);
			usbcin_pkg::res_t exp;
			if (pending_packets.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				exp = pending_packets.pop_front();
				if (got.status !== exp.status || got.send_packet !== exp.send_packet ||
						got.packet_bytes !== exp.packet_bytes ||
						got.packet_offset !== exp.packet_offset)
					report($sformatf("status %0d/%0d send %0d/%0d bytes %0d/%0d offset %0d/%0d",
						got.status, exp.status, got.send_packet, exp.send_packet,
						got.packet_bytes, exp.packet_bytes, got.packet_offset, exp.packet_offset));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	usbcin_evt_if evt_ch ();
	usbcin_res_if res_ch ();

	usb_control_in_data_stage_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	packet_tracker sb = new();

	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned stim_items = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, any hang or lost result ends up here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("usb_control_in_data_stage_top regression: fail");
			$finish;
		end
	end

	// monitor: both handshakes sampled at the edge, before the edge's own updates land
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1)
				sb.predict_packet({evt_ch.mode, evt_ch.length, evt_ch.request_length,
					evt_ch.fifo_fill});
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				sb.check_packet({res_ch.status, res_ch.send_packet, res_ch.packet_bytes,
					res_ch.packet_offset});
		end
	end

	// offers one beat and returns at the edge that takes it
	// the sender runs in bursts, a gap of idle cycles may open before a new burst
	task automatic send_event(input usbcin_pkg::evt_t e);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				evt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		evt_ch.valid <= 1'b1;
		evt_ch.mode <= e.mode;
		evt_ch.length <= e.length;
		evt_ch.request_length <= e.request_length;
		evt_ch.fifo_fill <= e.fifo_fill;
		do @(posedge clk); while (evt_ch.ready !== 1'b1);
	endtask

	task automatic send_fields(input logic [usbcin_pkg::MODE_W-1:0] mode,
			input logic [usbcin_pkg::LEN_W-1:0] len,
			input logic [usbcin_pkg::LEN_W-1:0] req,
			input logic [usbcin_pkg::FILL_W-1:0] fill);
		send_event({mode, len, req, fill});
		stim_items++;
	endtask

	// mostly an empty fifo so packets run full, sometimes partly or exactly full, rarely overfull
	function automatic logic [usbcin_pkg::FILL_W-1:0] pick_fill();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return '0;
		else if (r < 9)
			return usbcin_pkg::FILL_W'($urandom_range(1, usbcin_pkg::PKT_BYTES));
		else
			return usbcin_pkg::FILL_W'($urandom_range(usbcin_pkg::PKT_BYTES + 1, 15));
	endfunction

	// one well-formed transfer: start, a run of in-ready events, then usually an ending event
	task automatic run_transfer();
		int unsigned sel;
		int unsigned len;
		int unsigned req;
		int unsigned clamped;
		int unsigned n_in;
		int unsigned fin;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				len = 0;
				req = $urandom_range(0, 65535);
			end
			7: begin
				len = $urandom_range(0, 65535);
				req = $urandom_range(0, 40);
			end
			8: begin
				// long transfer, cut short by the ending event
				len = $urandom_range(0, 65535);
				req = $urandom_range(0, 65535);
			end
			9: begin
				len = $urandom_range(0, 40);
				req = $urandom_range(0, 40);
			end
			default: begin
				len = $urandom_range(1, 40);
				req = $urandom_range(len, 65535);
			end
		endcase
		clamped = (len > req) ? req : len;
		n_in = clamped / 6 + $urandom_range(0, 3);
		if (n_in > 24)
			n_in = $urandom_range(4, 24);
		send_fields(usbcin_pkg::MODE_START, usbcin_pkg::LEN_W'(len), usbcin_pkg::LEN_W'(req),
			usbcin_pkg::FILL_W'($urandom_range(0, 15)));
		repeat (n_in)
			send_fields(usbcin_pkg::MODE_IN_READY, usbcin_pkg::LEN_W'($urandom),
				usbcin_pkg::LEN_W'($urandom), pick_fill());
		fin = $urandom_range(0, 19);
		if (fin < 14)
			send_fields(usbcin_pkg::MODE_OUT, usbcin_pkg::LEN_W'($urandom),
				usbcin_pkg::LEN_W'($urandom), usbcin_pkg::FILL_W'($urandom));
		else if (fin < 16)
			send_fields(usbcin_pkg::MODE_SETUP, usbcin_pkg::LEN_W'($urandom),
				usbcin_pkg::LEN_W'($urandom), usbcin_pkg::FILL_W'($urandom));
		else if (fin < 18)
			send_fields(usbcin_pkg::MODE_DISC, usbcin_pkg::LEN_W'($urandom),
				usbcin_pkg::LEN_W'($urandom), usbcin_pkg::FILL_W'($urandom));
		else if (fin < 19)
			send_fields(usbcin_pkg::MODE_SUSP, usbcin_pkg::LEN_W'($urandom),
				usbcin_pkg::LEN_W'($urandom), usbcin_pkg::FILL_W'($urandom));
		// otherwise the next start lands on a running transfer
	endtask

	// receiver: its own mix of open, flaky and closed stretches, plus one long hold-off
	// so the two stages fill up and the input side stalls
	initial begin
		int unsigned pat;
		int unsigned span;
		bit          held_long;
		held_long = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_long && sb.accepted >= HOLD_AFTER) begin
				held_long = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					res_ch.ready <= 1'b0;
				end
			end
			pat = $urandom_range(0, 3);
			span = (pat == 3) ? $urandom_range(1, 8) : $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				case (pat)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 4) != 0);
					default: res_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	// stimulus
	initial begin
		usbcin_pkg::evt_t noise;
		arst_n <= 1'b0;
		evt_ch.valid <= 1'b0;
		evt_ch.mode <= usbcin_pkg::MODE_START;
		evt_ch.length <= '0;
		evt_ch.request_length <= '0;
		evt_ch.fifo_fill <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// events while idle are ignored, reserved modes too
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd0);
		send_fields(MODE_RSVD_6, 16'hFFFF, 16'hFFFF, 4'hF);
		// device offers nothing: zero-length packet straight away
		send_fields(usbcin_pkg::MODE_START, 16'd0, 16'd5, 4'd0);
		// in-ready and no event while awaiting the status stage
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd0);
		send_fields(MODE_RSVD_7, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_OUT, 16'd0, 16'd0, 4'd0);
		// host asks for nothing: no packet, straight to the status stage
		send_fields(usbcin_pkg::MODE_START, 16'd20, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_SETUP, 16'd0, 16'd0, 4'd0);
		// largest transfer, fifo empty, overfull, exactly full, part full
		send_fields(usbcin_pkg::MODE_START, 16'hFFFF, 16'hFFFF, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'hF);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd8);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd3);
		// restart while active, then a full last packet needs a trailing zero-length one
		send_fields(usbcin_pkg::MODE_START, 16'd16, 16'd20, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd2);
		send_fields(usbcin_pkg::MODE_DISC, 16'd0, 16'd0, 4'd0);
		// offered length clamped by the request, packets fill a part full fifo
		send_fields(usbcin_pkg::MODE_START, 16'd5, 16'd3, 4'd0);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd6);
		send_fields(usbcin_pkg::MODE_IN_READY, 16'd0, 16'd0, 4'd7);
		send_fields(usbcin_pkg::MODE_SUSP, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_OUT, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_START, 16'd0, 16'd0, 4'd0);
		send_fields(usbcin_pkg::MODE_OUT, 16'd0, 16'd0, 4'd0);

		// random part: mostly whole transfers, some loose events of any mode
		stim_items = 0;
		while (stim_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				noise.mode = usbcin_pkg::MODE_W'($urandom_range(0, 7));
				noise.length = usbcin_pkg::LEN_W'($urandom);
				noise.request_length = usbcin_pkg::LEN_W'($urandom);
				noise.fifo_fill = usbcin_pkg::FILL_W'($urandom);
				send_event(noise);
			end else begin
				run_transfer();
			end
		end
		evt_ch.valid <= 1'b0;

		// drain, then give a stray result time to show up
		while (sb.pending_packets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("usb_control_in_data_stage_top regression: pass");
		else
			$display("usb_control_in_data_stage_top regression: fail");
		$finish;
	end

endmodule
